[hw/rtl/sorted_alarm_wakeup_queue_macros.svh]
// assertion macros shared by the alarm queue rtl
// no dependencies; expects clk_i and rst_ni in the including module
`ifndef SORTED_ALARM_WAKEUP_QUEUE_MACROS_SVH
`define SORTED_ALARM_WAKEUP_QUEUE_MACROS_SVH

// property checked on every clock outside reset
`define SAWQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never hold outside reset
`define SAWQ_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[hw/rtl/sawq_pkg.sv]
// types and constants of the sorted alarm wakeup queue
// no dependencies
package sawq_pkg;

  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned RESULT_CNT_W = $clog2(MAX_RESULTS);
  localparam logic [15:0] INTERVAL_RESET = 16'd100;

  typedef enum logic [1:0] {
    KIND_WAKE  = 2'd0,
    KIND_FULL  = 2'd1,
    KIND_SHORT = 2'd2
  } kind_e;

  typedef enum logic {
    OP_SET  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef struct packed {
    logic        op;
    logic [23:0] duration;
    logic [7:0]  requester_id;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  woken_id;
    logic [31:0] due_tick;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] wake_tick;
    logic [7:0]  owner_id;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctrl_t;

endpackage

[hw/rtl/sawq_cell.sv]
// one slot of the sorted alarm chain: takes the new alarm, its left or right neighbor
// depends on sawq_pkg
module sawq_cell import sawq_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       occupied_i,
  input  entry_t     new_i,
  input  entry_t     prev_i,
  input  entry_t     next_i,
  input  logic       prev_gt_i,
  output logic       gt_o,
  output entry_t     entry_o
);

  entry_t entry_d, entry_q;

  // slot is empty or due strictly later than the new alarm
  assign gt_o = !occupied_i || (entry_q.wake_tick > new_i.wake_tick);

  always_comb begin
    entry_d = entry_q;
    priority if (ctrl_i.pop) begin
      entry_d = next_i;
    end else if (ctrl_i.ins && gt_o) begin
      entry_d = prev_gt_i ? prev_i : new_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[hw/rtl/sorted_alarm_wakeup_queue.sv]
// sorted alarm wakeup queue: tick counter plus a chain of alarm slots kept sorted
// set request: capture, then insert across the chain in ST_INSERT; a too short
// or rejected answer reaches the output register from ST_RESP once that register is free
// tick: advance the counter, then one wake result per cycle while the output register
// is free, paced by the single head-of-chain release port
// reset clears the counter and alarm count, interval returns to 100; depends on sawq_pkg
`include "sorted_alarm_wakeup_queue_macros.svh"

module sorted_alarm_wakeup_queue import sawq_pkg::*; #(
  parameter int unsigned MAX_ALARMS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ALARMS + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_INSERT = 4'b0010,
    ST_RESP   = 4'b0100,
    ST_DRAIN  = 4'b1000
  } state_e;

  state_e                  state_d, state_q;
  logic [31:0]             tick_d, tick_q;
  logic [15:0]             interval_q;
  logic [CNT_W-1:0]        count_d, count_q;
  logic [RESULT_CNT_W-1:0] nres_d, nres_q;
  logic                    out_valid_d, out_valid_q;
  out_item_t               out_d, out_q;
  entry_t                  req_d, req_q;
  kind_e                   resp_kind_d, resp_kind_q;

  cell_ctrl_t ctrl;
  entry_t     cells [MAX_ALARMS];
  logic       gts   [MAX_ALARMS];

  logic        in_xfer, out_free;
  logic [32:0] sum;
  logic [31:0] due;
  logic        head_exp, next_exp, last_res;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign sum = {1'b0, tick_q} + {9'b0, in_data_i.duration};
  assign due = sum[32] ? '1 : sum[31:0];

  assign head_exp = (count_q > CNT_W'(0)) && (cells[0].wake_tick <= tick_q);
  assign next_exp = (count_q > CNT_W'(1)) && (cells[1].wake_tick <= tick_q);
  assign last_res = !next_exp || (nres_q == RESULT_CNT_W'(MAX_RESULTS - 1));

  generate
    for (genvar i = 0; i < MAX_ALARMS; i++) begin : g_cell
      entry_t prev_e, next_e;
      logic   prev_gt;
      if (i == 0) begin : g_first
        assign prev_e  = req_q;
        assign prev_gt = 1'b0;
      end else begin : g_mid
        assign prev_e  = cells[i-1];
        assign prev_gt = gts[i-1];
      end
      if (i == MAX_ALARMS - 1) begin : g_last
        assign next_e = cells[i];
      end else begin : g_body
        assign next_e = cells[i+1];
      end
      sawq_cell u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl),
        .occupied_i (count_q > CNT_W'(i)),
        .new_i      (req_q),
        .prev_i     (prev_e),
        .next_i     (next_e),
        .prev_gt_i  (prev_gt),
        .gt_o       (gts[i]),
        .entry_o    (cells[i])
      );
    end
  endgenerate

  always_comb begin
    state_d     = state_q;
    tick_d      = tick_q;
    count_d     = count_q;
    nres_d      = nres_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    req_d       = req_q;
    resp_kind_d = resp_kind_q;
    ctrl        = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_data_i.op == OP_TICK) begin
            if (tick_q != '1) begin
              tick_d = tick_q + 32'd1;
            end
            nres_d  = '0;
            state_d = ST_DRAIN;
          end else begin
            req_d.wake_tick = due;
            req_d.owner_id  = in_data_i.requester_id;
            priority if (in_data_i.duration <= {9'b0, interval_q[15:1]}) begin
              resp_kind_d = KIND_SHORT;
              state_d     = ST_RESP;
            end else if (count_q == CNT_W'(MAX_ALARMS)) begin
              resp_kind_d = KIND_FULL;
              state_d     = ST_RESP;
            end else begin
              state_d = ST_INSERT;
            end
          end
        end
      end
      ST_INSERT: begin
        ctrl.ins = 1'b1;
        count_d  = count_q + CNT_W'(1);
        state_d  = ST_IDLE;
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{kind: resp_kind_q, woken_id: req_q.owner_id,
                          due_tick: req_q.wake_tick, last: 1'b1};
          state_d     = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (!head_exp) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{kind: KIND_WAKE, woken_id: cells[0].owner_id,
                          due_tick: cells[0].wake_tick, last: last_res};
          ctrl.pop    = 1'b1;
          count_d     = count_q - CNT_W'(1);
          nres_d      = nres_q + RESULT_CNT_W'(1);
          if (last_res) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_q      <= '0;
      interval_q  <= INTERVAL_RESET;
      count_q     <= '0;
      nres_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      count_q     <= count_d;
      nres_q      <= nres_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q       <= out_d;
    req_q       <= req_d;
    resp_kind_q <= resp_kind_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SAWQ_ASSERT(a_count_bound, count_q <= CNT_W'(MAX_ALARMS), "alarm count above table size")
  `SAWQ_ASSERT(a_insert_room, state_q == ST_INSERT |-> count_q < CNT_W'(MAX_ALARMS), "insert into full table")
  `SAWQ_ASSERT(a_pop_expired, ctrl.pop |-> head_exp && out_free, "released alarm not yet due")
  `SAWQ_ASSERT(a_head_sorted, count_q > CNT_W'(1) |-> cells[0].wake_tick <= cells[1].wake_tick, "chain head out of order")
  `SAWQ_NEVER(a_ins_pop, ctrl.ins && ctrl.pop, "insert and release in one cycle")

endmodule

[sim/sorted_alarm_wakeup_queue_checker.sv]
// checker for the sorted alarm wakeup queue: watches both channels and the interval port,
// keeps its own copy of the tick counter and alarm table, and compares every result transfer
// depends on sawq_pkg
module sorted_alarm_wakeup_queue_checker import sawq_pkg::*; #(
  parameter int unsigned MAX_ALARMS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_LIMIT = 10;

  logic [15:0] interval_q;
  logic [31:0] now_tick;
  entry_t      alarm_table [MAX_ALARMS];
  int unsigned alarm_cnt;
  int unsigned mismatches;
  out_item_t   awaited_results [$];

  function automatic string show_result(input out_item_t r);
    return $sformatf("kind %0d id 0x%02h due 0x%08h last %0b",
                     r.kind, r.woken_id, r.due_tick, r.last);
  endfunction

  task automatic model_request(input in_item_t it);
    logic [32:0] sum;
    logic [31:0] due;
    int unsigned pos;
    int unsigned n;
    out_item_t   res;
    if (op_e'(it.op) == OP_SET) begin
      sum = {1'b0, now_tick} + 33'(it.duration);
      due = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      res.woken_id = it.requester_id;
      res.due_tick = due;
      res.last = 1'b1;
      if (32'(it.duration) <= 32'(interval_q >> 1)) begin
        res.kind = KIND_SHORT;
        awaited_results.push_back(res);
      end else if (alarm_cnt >= MAX_ALARMS) begin
        res.kind = KIND_FULL;
        awaited_results.push_back(res);
      end else begin
        // equal wake ticks stay in arrival order
        pos = alarm_cnt;
        while (pos > 0 && alarm_table[pos - 1].wake_tick > due) begin
          alarm_table[pos] = alarm_table[pos - 1];
          pos--;
        end
        alarm_table[pos].wake_tick = due;
        alarm_table[pos].owner_id = it.requester_id;
        alarm_cnt++;
      end
    end else begin
      if (now_tick != 32'hFFFF_FFFF) now_tick++;
      n = 0;
      while (n < MAX_RESULTS && n < alarm_cnt && alarm_table[n].wake_tick <= now_tick) n++;
      for (int unsigned k = 0; k < n; k++) begin
        res.kind = KIND_WAKE;
        res.woken_id = alarm_table[k].owner_id;
        res.due_tick = alarm_table[k].wake_tick;
        res.last = (k == n - 1);
        awaited_results.push_back(res);
      end
      for (int unsigned i = n; i < alarm_cnt; i++) alarm_table[i - n] = alarm_table[i];
      alarm_cnt -= n;
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (awaited_results.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("unexpected result: got %s", show_result(got));
    end else begin
      want = awaited_results.pop_front();
      if (want.kind != got.kind || want.woken_id != got.woken_id ||
          want.due_tick != got.due_tick || want.last != got.last) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("result mismatch: expected %s, got %s", show_result(want), show_result(got));
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q = INTERVAL_RESET;
      now_tick = '0;
      alarm_cnt = 0;
      mismatches = 0;
      awaited_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_result(out_data_i);
      if (in_valid_i && in_ready_i) model_request(in_data_i);
      if (cfg_we_i) interval_q = cfg_wdata_i;
    end
    fail_count_o = mismatches;
    pending_o = awaited_results.size();
  end

endmodule

[sim/sorted_alarm_wakeup_queue_test.sv]
// top of the alarm queue testbench: clock, reset, set and tick requests, interval writes,
// result back-pressure, watchdog and verdict
// depends on sawq_pkg, sorted_alarm_wakeup_queue and sorted_alarm_wakeup_queue_checker
module sorted_alarm_wakeup_queue_test;
  import sawq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_ALARMS     = 16;
  localparam int unsigned MAX_GAP        = 18;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned TAIL_CYCLES    = 8;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles = 0;
  int unsigned threshold = 32'(INTERVAL_RESET >> 1);
  bit          busy = 1'b0;
  bit          hold_pending = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  sorted_alarm_wakeup_queue #(
    .MAX_ALARMS(MAX_ALARMS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  sorted_alarm_wakeup_queue_checker #(
    .MAX_ALARMS(MAX_ALARMS)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  function automatic int unsigned draw_gap();
    if (busy || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic in_item_t set_req(input logic [23:0] dur, input logic [7:0] id);
    in_item_t it;
    it.op = OP_SET;
    it.duration = dur;
    it.requester_id = id;
    return it;
  endfunction

  // unused fields of a tick carry random bits
  function automatic in_item_t tick_req();
    in_item_t it;
    it.op = OP_TICK;
    it.duration = 24'($urandom());
    it.requester_id = 8'($urandom());
    return it;
  endfunction

  function automatic logic [23:0] pick_duration();
    int unsigned r;
    r = $urandom_range(0, 63);
    if (r == 0) return 24'($urandom());
    if (r < 16) return 24'($urandom_range(0, threshold));
    return 24'(threshold + 1 + $urandom_range(0, 24));
  endfunction

  task automatic send_item(input in_item_t item);
    int unsigned gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
  endtask

  task automatic write_interval(input logic [15:0] value);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    threshold = 32'(value >> 1);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned items);
    int unsigned sent;
    int unsigned burst;
    logic [23:0] dur;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 1) == 1) begin
        send_item(tick_req());
        sent++;
      end else begin
        // occasional run of requests that share one wake tick
        dur = pick_duration();
        burst = ($urandom_range(0, 15) == 0) ? $urandom_range(2, 6) : 1;
        repeat (burst) send_item(set_req(dur, 8'($urandom())));
        sent += burst;
      end
    end
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    write_interval(16'd4);
    send_item(set_req(24'd0, 8'h00));
    send_item(set_req(24'd2, 8'hFF));
    for (int unsigned k = 0; k < MAX_ALARMS; k++) send_item(set_req(24'd3, 8'(8'h10 + k)));
    send_item(set_req(24'd3, 8'hEE));
    repeat (3) send_item(tick_req());
    send_item(set_req(24'hFF_FFFF, 8'h80));
    send_item(set_req(24'd3, 8'h42));

    write_interval(16'd1);
    random_phase(90);
    busy = 1'b1;
    write_interval(16'd0);
    random_phase(70);
    busy = 1'b0;
    write_interval(16'd10);
    random_phase(80);
    write_interval(16'($urandom_range(2, 40)));
    random_phase(80);
    write_interval(16'd100);
    random_phase(80);
    write_interval(16'hFFFF);
    busy = 1'b1;
    hold_pending = 1'b1;
    random_phase(70);
    busy = 1'b0;

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    wait (rst_ni);
    forever begin
      stall = draw_gap();
      if (hold_pending) begin
        stall = HOLD_CYCLES;
        hold_pending = 1'b0;
      end
      repeat (stall) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // no transfer on either channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
